// ===== rtl/bitmap_font_text_renderer_macros.svh =====
// Assertion macros for the bitmap font text renderer.
// Expects clk and arst_n in the scope of the module that uses them.
`ifndef BITMAP_FONT_TEXT_RENDERER_MACROS_SVH
`define BITMAP_FONT_TEXT_RENDERER_MACROS_SVH

// Consequent holds in the same cycle as the antecedent.
`define BFTR_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define BFTR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/bftr_pkg.sv =====
// Types and constants of the bitmap font text renderer.
// No dependencies; used by bitmap_font_text_renderer.
package bftr_pkg;

	typedef enum logic [1:0] {
		KIND_GLYPH  = 2'd0,
		KIND_BYTE   = 2'd1,
		KIND_CHAR   = 2'd2,
		KIND_CURSOR = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		CFG_FIRST_CHAR    = 3'd0,
		CFG_LAST_CHAR     = 3'd1,
		CFG_SPACE_WIDTH   = 3'd2,
		CFG_TEXT_SCALE    = 3'd3,
		CFG_WRAP_ENABLE   = 3'd4,
		CFG_DISPLAY_WIDTH = 3'd5,
		CFG_FG_COLOR      = 3'd6,
		CFG_BG_COLOR      = 3'd7
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ENTRY,
		ST_BASE,
		ST_READ,
		ST_LAST,
		ST_EMIT,
		ST_ADV
	} state_t;

	localparam logic [7:0] CH_NEWLINE = 8'd10;
	localparam logic [7:0] CH_RETURN  = 8'd13;

	typedef struct packed {
		kind_t              kind;
		logic [11:0]        table_address;
		logic [11:0]        glyph_offset;
		logic [4:0]         glyph_width;
		logic [5:0]         glyph_height;
		logic [7:0]         bitmap_byte;
		logic [7:0]         char_code;
		logic signed [15:0] new_x;
		logic signed [15:0] new_y;
	} req_item_t;

	typedef struct packed {
		logic signed [15:0] column_x;
		logic signed [15:0] column_y;
		logic [5:0]         column_height;
		logic [31:0]        column_bits;
		logic [15:0]        draw_color;
		logic [15:0]        back_color;
		logic               paint_back;
		logic               last;
	} col_item_t;

endpackage

// ===== rtl/bftr_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies; instanced by bitmap_font_text_renderer.
module bftr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                                     clk,
	input  logic                                     wr_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                         wr_data,
	input  logic                                     rd_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== rtl/bitmap_font_text_renderer.sv =====
// Bitmap font text renderer: glyph table, font bitmap, cursor and column output.
// Depends on bftr_pkg, bftr_ram and bitmap_font_text_renderer_macros.svh.
//
// Channel   Handshake                 Payload            Moves
// request   req_valid / req_ready     req_item           glyph entry, byte, char, cursor
// column    col_valid / col_ready     col_item           one glyph column
// config    cfg_we                    cfg_index/cfg_data register write
//
// A request is taken only in the idle step; all but a drawn glyph finish there.
// A drawn glyph steps through entry and base, then per column ceil(height/8) reads
// of the single bitmap read port, a last step and an emit step, and ends with a
// cursor advance; zero height skips reads and last step, zero width skips columns.
// Reset puts cursor, registers and control in reset state; the two stores hold
// nothing until written. A stalled column output holds the sequencer in its emit step.
`include "bitmap_font_text_renderer_macros.svh"

module bitmap_font_text_renderer #(
	parameter int GLYPH_SLOTS      = 256,
	parameter int BITMAP_BYTES     = 4096,
	parameter int MAX_GLYPH_WIDTH  = 16,
	parameter int MAX_GLYPH_HEIGHT = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_ready,
	input  bftr_pkg::req_item_t   req_item,
	output logic                  col_valid,
	input  logic                  col_ready,
	output bftr_pkg::col_item_t   col_item,
	input  logic                  cfg_we,
	input  logic [2:0]            cfg_index,
	input  logic [15:0]           cfg_data
);

	localparam int GW     = (GLYPH_SLOTS > 1) ? $clog2(GLYPH_SLOTS) : 1;
	localparam int AW     = $clog2(BITMAP_BYTES);
	localparam int WCAP   = (MAX_GLYPH_WIDTH < 16) ? MAX_GLYPH_WIDTH : 16;
	localparam int HCAP   = (MAX_GLYPH_HEIGHT < 32) ? MAX_GLYPH_HEIGHT : 32;
	localparam int SHIFT  = 28;
	localparam int RECIP  = ((1 << SHIFT) + BITMAP_BYTES - 1) / BITMAP_BYTES;
	localparam int RW     = $clog2(RECIP + 1);
	localparam int PW     = RW + 12;

	localparam logic [RW-1:0] RECIP_C  = RW'(RECIP);
	localparam logic [AW-1:0] ADDR_TOP = AW'(BITMAP_BYTES - 1);

	bftr_pkg::state_t state_q, state_d;

	logic [7:0]  first_q, last_q;
	logic [3:0]  space_q, scale_q;
	logic        wrap_q;
	logic [10:0] dispw_q;
	logic [15:0] fg_q, bg_q;

	logic [15:0] x_q, y_q;

	logic [11:0]   off_q;
	logic [4:0]    w_q;
	logic [5:0]    h_q;
	logic [2:0]    bpc_q;
	logic [11:0]   q_q;
	logic [AW-1:0] addr_q;
	logic [4:0]    col_q;
	logic [1:0]    k_q;
	logic          rdv_s1;
	logic [1:0]    k_s1;
	logic [31:0]   bits_q;

	bftr_pkg::col_item_t col_item_q;
	logic                col_valid_q;

	logic [22:0] gt_rdata;
	logic [7:0]  bm_rdata;
	logic        gt_rd_en, bm_rd_en;
	logic        gt_we, bm_we;

	logic        req_fire;
	logic [7:0]  slot;
	logic        in_font;
	logic        glyph_req;
	logic        is_char;
	logic [4:0]  w_cap;
	logic [5:0]  h_cap;

	logic [11:0]   e_off;
	logic [4:0]    e_w;
	logic [5:0]    e_h;
	logic [2:0]    e_bpc;
	logic [PW-1:0] prod;
	logic [11:0]   rem;

	logic        last_byte, last_col, emit_go;
	logic [31:0] mask;
	logic [7:0]  rev;

	logic [15:0]        x_adv;
	logic signed [16:0] x_ext, lim;
	logic               wrap_hit;

	logic in_emit, in_read_step, in_adv;

	// Request decode
	assign req_fire  = req_valid && (state_q == bftr_pkg::ST_IDLE);
	assign is_char   = (req_item.kind == bftr_pkg::KIND_CHAR);
	assign slot      = req_item.char_code - first_q;
	assign in_font   = (req_item.char_code >= first_q) && (req_item.char_code <= last_q)
		&& (32'(slot) < GLYPH_SLOTS);
	assign glyph_req = req_valid && is_char && in_font
		&& (req_item.char_code != bftr_pkg::CH_NEWLINE)
		&& (req_item.char_code != bftr_pkg::CH_RETURN);

	assign w_cap = (32'(req_item.glyph_width) > WCAP) ? 5'(WCAP) : req_item.glyph_width;
	assign h_cap = (32'(req_item.glyph_height) > HCAP) ? 6'(HCAP) : req_item.glyph_height;
	assign gt_we = req_fire && (req_item.kind == bftr_pkg::KIND_GLYPH)
		&& (32'(req_item.table_address) < GLYPH_SLOTS);
	assign bm_we = req_fire && (req_item.kind == bftr_pkg::KIND_BYTE)
		&& (32'(req_item.table_address) < BITMAP_BYTES);

	// Glyph entry and start address of its bitmap
	assign e_off = gt_rdata[11:0];
	assign e_w   = gt_rdata[16:12];
	assign e_h   = gt_rdata[22:17];
	assign e_bpc = 3'((7'(e_h) + 7'd7) >> 3);
	assign prod  = PW'(e_off) * PW'(RECIP_C);
	assign rem   = off_q - 12'(32'(q_q) * BITMAP_BYTES);

	// Column assembly
	assign last_byte = (k_q == 2'(bpc_q - 3'd1));
	assign last_col  = (col_q == w_q - 5'd1);
	assign emit_go   = (state_q == bftr_pkg::ST_EMIT) && (!col_valid_q || col_ready);
	assign mask      = 32'((33'd1 << h_q) - 33'd1);

	assign in_emit      = (state_q == bftr_pkg::ST_EMIT);
	assign in_read_step = (state_q == bftr_pkg::ST_READ) || (state_q == bftr_pkg::ST_LAST);
	assign in_adv       = (state_q == bftr_pkg::ST_ADV);

	always_comb begin
		for (int m = 0; m < 8; m++) begin
			rev[m] = bm_rdata[7-m];
		end
	end

	// Cursor advance after a glyph
	assign x_adv    = x_q + 16'(w_q) + 16'(space_q);
	assign x_ext    = {x_adv[15], x_adv};
	assign lim      = $signed({6'd0, dispw_q}) - 17'sd8;
	assign wrap_hit = wrap_q && (x_ext > lim);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bftr_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		req_ready = 1'b0;
		gt_rd_en  = 1'b0;
		bm_rd_en  = 1'b0;
		case (state_q)
			bftr_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				if (glyph_req) begin
					gt_rd_en = 1'b1;
					state_d  = bftr_pkg::ST_ENTRY;
				end
			end
			bftr_pkg::ST_ENTRY: begin
				state_d = bftr_pkg::ST_BASE;
			end
			bftr_pkg::ST_BASE: begin
				if (w_q == 5'd0) begin
					state_d = bftr_pkg::ST_ADV;
				end else if (bpc_q == 3'd0) begin
					state_d = bftr_pkg::ST_EMIT;
				end else begin
					state_d = bftr_pkg::ST_READ;
				end
			end
			bftr_pkg::ST_READ: begin
				bm_rd_en = 1'b1;
				if (last_byte) begin
					state_d = bftr_pkg::ST_LAST;
				end
			end
			bftr_pkg::ST_LAST: begin
				state_d = bftr_pkg::ST_EMIT;
			end
			bftr_pkg::ST_EMIT: begin
				if (emit_go) begin
					if (last_col) begin
						state_d = bftr_pkg::ST_ADV;
					end else if (bpc_q == 3'd0) begin
						state_d = bftr_pkg::ST_EMIT;
					end else begin
						state_d = bftr_pkg::ST_READ;
					end
				end
			end
			bftr_pkg::ST_ADV: begin
				state_d = bftr_pkg::ST_IDLE;
			end
			default: begin
				state_d = bftr_pkg::ST_IDLE;
			end
		endcase
	end

	// Registers, cursor and control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q     <= 8'd32;
			last_q      <= 8'd126;
			space_q     <= 4'd1;
			scale_q     <= 4'd1;
			wrap_q      <= 1'b1;
			dispw_q     <= 11'd128;
			fg_q        <= 16'hFFFF;
			bg_q        <= 16'hFFFF;
			x_q         <= 16'd0;
			y_q         <= 16'd0;
			col_valid_q <= 1'b0;
			rdv_s1      <= 1'b0;
			col_q       <= 5'd0;
			k_q         <= 2'd0;
		end else begin
			if (cfg_we) begin
				case (bftr_pkg::cfg_reg_t'(cfg_index))
					bftr_pkg::CFG_FIRST_CHAR:    first_q <= cfg_data[7:0];
					bftr_pkg::CFG_LAST_CHAR:     last_q  <= cfg_data[7:0];
					bftr_pkg::CFG_SPACE_WIDTH:   space_q <= cfg_data[3:0];
					bftr_pkg::CFG_TEXT_SCALE:    scale_q <= cfg_data[3:0];
					bftr_pkg::CFG_WRAP_ENABLE:   wrap_q  <= cfg_data[0];
					bftr_pkg::CFG_DISPLAY_WIDTH: dispw_q <= cfg_data[10:0];
					bftr_pkg::CFG_FG_COLOR:      fg_q    <= cfg_data;
					bftr_pkg::CFG_BG_COLOR:      bg_q    <= cfg_data;
					default: ;
				endcase
			end

			if (req_fire && (req_item.kind == bftr_pkg::KIND_CURSOR)) begin
				x_q <= req_item.new_x;
				y_q <= req_item.new_y;
			end else if (req_fire && is_char
				&& (req_item.char_code == bftr_pkg::CH_NEWLINE)) begin
				x_q <= 16'd0;
				y_q <= y_q + {9'd0, scale_q, 3'd0};
			end else if (state_q == bftr_pkg::ST_ADV) begin
				if (wrap_hit) begin
					x_q <= 16'd0;
					y_q <= y_q + 16'(h_q);
				end else begin
					x_q <= x_adv;
				end
			end

			if (emit_go) begin
				col_valid_q <= 1'b1;
			end else if (col_ready) begin
				col_valid_q <= 1'b0;
			end

			rdv_s1 <= bm_rd_en;

			if (state_q == bftr_pkg::ST_BASE) begin
				col_q <= 5'd0;
				k_q   <= 2'd0;
			end else if (emit_go) begin
				col_q <= col_q + 5'd1;
				k_q   <= 2'd0;
			end else if (bm_rd_en) begin
				k_q <= k_q + 2'd1;
			end
		end
	end

	// Glyph, address and column payload
	always_ff @(posedge clk) begin
		if (state_q == bftr_pkg::ST_ENTRY) begin
			off_q <= e_off;
			w_q   <= e_w;
			h_q   <= e_h;
			bpc_q <= e_bpc;
			q_q   <= 12'(prod >> SHIFT);
		end
		if (state_q == bftr_pkg::ST_BASE) begin
			addr_q <= AW'(rem);
		end else if (bm_rd_en) begin
			addr_q <= (addr_q == ADDR_TOP) ? '0 : addr_q + 1'b1;
		end
		k_s1 <= k_q;
		if (rdv_s1) begin
			bits_q[8*k_s1 +: 8] <= rev;
		end
		if (emit_go) begin
			col_item_q.column_x      <= x_q + 16'(col_q);
			col_item_q.column_y      <= y_q;
			col_item_q.column_height <= h_q;
			col_item_q.column_bits   <= bits_q & mask;
			col_item_q.draw_color    <= fg_q;
			col_item_q.back_color    <= bg_q;
			col_item_q.paint_back    <= (bg_q != fg_q);
			col_item_q.last          <= last_col;
		end
	end

	assign col_valid = col_valid_q;
	assign col_item  = col_item_q;

	bftr_ram #(
		.WIDTH(23),
		.DEPTH(GLYPH_SLOTS)
	) u_glyph_ram (
		.clk     (clk),
		.wr_en   (gt_we),
		.wr_addr (GW'(req_item.table_address)),
		.wr_data ({h_cap, w_cap, req_item.glyph_offset}),
		.rd_en   (gt_rd_en),
		.rd_addr (GW'(slot)),
		.rd_data (gt_rdata)
	);

	bftr_ram #(
		.WIDTH(8),
		.DEPTH(BITMAP_BYTES)
	) u_bitmap_ram (
		.clk     (clk),
		.wr_en   (bm_we),
		.wr_addr (AW'(req_item.table_address)),
		.wr_data (req_item.bitmap_byte),
		.rd_en   (bm_rd_en),
		.rd_addr (addr_q),
		.rd_data (bm_rdata)
	);

	`BFTR_ASSERT_NOW(a_rd_addr_range, bm_rd_en, 32'(addr_q) < BITMAP_BYTES, "read beyond store")
	`BFTR_ASSERT_NOW(a_col_from_emit, $rose(col_valid_q), $past(in_emit), "column outside emit")
	`BFTR_ASSERT_NOW(a_col_in_glyph, in_emit, col_q < w_q, "column index past glyph width")
	`BFTR_ASSERT_NOW(a_data_in_read, rdv_s1, in_read_step, "bitmap data outside read")
	`BFTR_ASSERT_NEXT(a_last_advances, emit_go && last_col, in_adv, "cursor not advanced")

endmodule

// ===== bench/tb_bitmap_font_text_renderer.sv =====
// Self-checking testbench for bitmap_font_text_renderer: glyph, bitmap, cursor and
// character requests against a built-in column predictor, over several register settings.
// Depends on bftr_pkg and the renderer RTL only.
module tb_bitmap_font_text_renderer;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS       = 256;
	localparam int BYTES       = 4096;
	localparam int WIDTH_CAP   = 16;
	localparam int HEIGHT_CAP  = 32;
	localparam int DRAIN       = 40;
	localparam int QUIET_LIMIT = 2000;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                req_valid = 1'b0;
	logic                req_ready;
	bftr_pkg::req_item_t req_item = '0;
	logic                col_valid;
	logic                col_ready = 1'b0;
	bftr_pkg::col_item_t col_item;
	logic                cfg_we = 1'b0;
	logic [2:0]          cfg_index = '0;
	logic [15:0]         cfg_data = '0;

	bitmap_font_text_renderer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_item  (req_item),
		.col_valid (col_valid),
		.col_ready (col_ready),
		.col_item  (col_item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #10 clk = ~clk;

	// renderer state as predicted from accepted requests
	logic [11:0] slot_offset [SLOTS];
	logic [4:0]  slot_width  [SLOTS];
	logic [5:0]  slot_height [SLOTS];
	logic [7:0]  font_bytes  [BYTES];
	logic [15:0] pen_x = '0;
	logic [15:0] pen_y = '0;
	logic [7:0]  font_first = 8'd32;
	logic [7:0]  font_last = 8'd126;
	logic [3:0]  space_gap = 4'd1;
	logic [3:0]  line_scale = 4'd1;
	logic        wrap_on = 1'b1;
	logic [10:0] disp_width = 11'd128;
	logic [15:0] fg = 16'hFFFF;
	logic [15:0] bg = 16'hFFFF;

	bftr_pkg::col_item_t expected_columns [$];
	bftr_pkg::req_item_t req_pending [$];

	// what the stimulus side knows has been queued for writing
	bit          known_slot [SLOTS];
	bit          known_byte [BYTES];
	logic [11:0] plan_off [SLOTS];
	int          plan_w [SLOTS];
	int          plan_h [SLOTS];
	int          gen_first = 32;
	int          gen_last = 126;
	int          gen_width = 128;

	bit req_taken;
	bit idle_on;
	int send_gap;
	int sink_hold;
	int queued;
	int accepted_reqs;
	int columns_checked;
	int settings_applied;
	int error_count;
	int quiet_cycles;

	task automatic log_error(string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		error_count++;
	endtask

	task automatic compare_field(string name, logic [31:0] got, logic [31:0] want);
		if (got !== want)
			log_error($sformatf("%s got %0h expected %0h", name, got, want));
	endtask

	task automatic apply_reg(logic [2:0] idx, logic [15:0] v);
		case (bftr_pkg::cfg_reg_t'(idx))
			bftr_pkg::CFG_FIRST_CHAR:    font_first = v[7:0];
			bftr_pkg::CFG_LAST_CHAR:     font_last = v[7:0];
			bftr_pkg::CFG_SPACE_WIDTH:   space_gap = v[3:0];
			bftr_pkg::CFG_TEXT_SCALE:    line_scale = v[3:0];
			bftr_pkg::CFG_WRAP_ENABLE:   wrap_on = v[0];
			bftr_pkg::CFG_DISPLAY_WIDTH: disp_width = v[10:0];
			bftr_pkg::CFG_FG_COLOR:      fg = v;
			bftr_pkg::CFG_BG_COLOR:      bg = v;
			default: ;
		endcase
	endtask

	task automatic predict_columns(bftr_pkg::req_item_t r);
		bftr_pkg::col_item_t c;
		logic [11:0]         a;
		logic [31:0]         bits;
		int                  slot;
		int                  w;
		int                  h;
		int                  bpc;
		int                  i;
		int                  j;
		case (r.kind)
			bftr_pkg::KIND_GLYPH: begin
				if (r.table_address < SLOTS) begin
					slot_offset[r.table_address[7:0]] = r.glyph_offset;
					slot_width[r.table_address[7:0]] =
						(r.glyph_width > WIDTH_CAP) ? 5'(WIDTH_CAP) : r.glyph_width;
					slot_height[r.table_address[7:0]] =
						(r.glyph_height > HEIGHT_CAP) ? 6'(HEIGHT_CAP) : r.glyph_height;
				end
			end
			bftr_pkg::KIND_BYTE: font_bytes[r.table_address] = r.bitmap_byte;
			bftr_pkg::KIND_CURSOR: begin
				pen_x = r.new_x;
				pen_y = r.new_y;
			end
			default: begin
				if (r.char_code == bftr_pkg::CH_NEWLINE) begin
					pen_y = pen_y + 16'(line_scale) * 16'd8;
					pen_x = '0;
				end else if (r.char_code != bftr_pkg::CH_RETURN &&
						r.char_code >= font_first && r.char_code <= font_last) begin
					slot = r.char_code - font_first;
					w = slot_width[slot];
					h = slot_height[slot];
					bpc = (h + 7) / 8;
					for (j = 0; j < w; j++) begin
						bits = '0;
						for (i = 0; i < h; i++) begin
							a = 12'(slot_offset[slot] + j * bpc + i / 8);
							bits[i] = font_bytes[a][7 - i % 8];
						end
						c.column_x = pen_x + 16'(j);
						c.column_y = pen_y;
						c.column_height = 6'(h);
						c.column_bits = bits;
						c.draw_color = fg;
						c.back_color = bg;
						c.paint_back = (bg != fg);
						c.last = (j == w - 1);
						expected_columns.push_back(c);
					end
					pen_x = pen_x + 16'(w) + 16'(space_gap);
					if (wrap_on && int'($signed(pen_x)) > int'(disp_width) - 8) begin
						pen_y = pen_y + 16'(h);
						pen_x = '0;
					end
				end
			end
		endcase
	endtask

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// monitor, predictor and watchdog
	always @(posedge clk) begin
		bftr_pkg::col_item_t want;
		if (arst_n) begin
			if (cfg_we)
				apply_reg(cfg_index, cfg_data);
			if (req_valid && req_ready) begin
				predict_columns(req_item);
				req_taken = 1'b1;
				accepted_reqs++;
			end
			if (col_valid && col_ready) begin
				if (expected_columns.size() == 0) begin
					log_error($sformatf("column x=%0d y=%0d with none expected",
						col_item.column_x, col_item.column_y));
				end else begin
					want = expected_columns.pop_front();
					compare_field("column_x", col_item.column_x, want.column_x);
					compare_field("column_y", col_item.column_y, want.column_y);
					compare_field("column_height", col_item.column_height, want.column_height);
					compare_field("column_bits", col_item.column_bits, want.column_bits);
					compare_field("draw_color", col_item.draw_color, want.draw_color);
					compare_field("back_color", col_item.back_color, want.back_color);
					compare_field("paint_back", col_item.paint_back, want.paint_back);
					compare_field("last", col_item.last, want.last);
					columns_checked++;
				end
			end
			if ((req_valid && req_ready) || (col_valid && col_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("no request or column moved for %0d cycles", QUIET_LIMIT);
				$display("tb_bitmap_font_text_renderer: errors");
				$finish;
			end
		end
	end

	// request driver: hold until taken, then advance after a random gap while idle_on is set
	always @(negedge clk) begin
		if (!req_valid || req_taken) begin
			req_taken = 1'b0;
			if (send_gap > 0) begin
				send_gap--;
				req_valid <= 1'b0;
			end else if (req_pending.size() > 0) begin
				req_item <= req_pending.pop_front();
				req_valid <= 1'b1;
				send_gap = idle_on ? gap_len() : 0;
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// column sink with random back-pressure while idle_on is set
	always @(negedge clk) begin
		if (sink_hold > 0) begin
			sink_hold--;
			col_ready <= 1'b0;
		end else begin
			col_ready <= 1'b1;
			if (idle_on && $urandom_range(0, 2) == 0)
				sink_hold = gap_len();
		end
	end

	function automatic bftr_pkg::req_item_t noisy_req(bftr_pkg::kind_t k);
		logic [95:0]         noise;
		bftr_pkg::req_item_t r;
		noise = {$urandom, $urandom, $urandom};
		r = noise[$bits(bftr_pkg::req_item_t)-1:0];
		r.kind = k;
		return r;
	endfunction

	task automatic push_req(bftr_pkg::req_item_t r);
		int s;
		req_pending.push_back(r);
		if (r.kind == bftr_pkg::KIND_GLYPH && r.table_address < SLOTS) begin
			s = r.table_address;
			known_slot[s] = 1'b1;
			plan_off[s] = r.glyph_offset;
			plan_w[s] = (r.glyph_width > WIDTH_CAP) ? WIDTH_CAP : r.glyph_width;
			plan_h[s] = (r.glyph_height > HEIGHT_CAP) ? HEIGHT_CAP : r.glyph_height;
		end
		if (r.kind == bftr_pkg::KIND_BYTE)
			known_byte[r.table_address] = 1'b1;
		queued++;
	endtask

	task automatic push_entry(logic [11:0] addr, logic [11:0] off, logic [4:0] w,
			logic [5:0] h);
		bftr_pkg::req_item_t r;
		r = noisy_req(bftr_pkg::KIND_GLYPH);
		r.table_address = addr;
		r.glyph_offset = off;
		r.glyph_width = w;
		r.glyph_height = h;
		push_req(r);
	endtask

	task automatic push_byte(logic [11:0] addr, logic [7:0] v);
		bftr_pkg::req_item_t r;
		r = noisy_req(bftr_pkg::KIND_BYTE);
		r.table_address = addr;
		r.bitmap_byte = v;
		push_req(r);
	endtask

	task automatic push_char(logic [7:0] code);
		bftr_pkg::req_item_t r;
		r = noisy_req(bftr_pkg::KIND_CHAR);
		r.char_code = code;
		push_req(r);
	endtask

	task automatic push_cursor(logic [15:0] x, logic [15:0] y);
		bftr_pkg::req_item_t r;
		r = noisy_req(bftr_pkg::KIND_CURSOR);
		r.new_x = x;
		r.new_y = y;
		push_req(r);
	endtask

	// entry plus every bitmap byte it covers that is not yet queued, and some that are
	task automatic define_glyph(int slot, logic [11:0] off, logic [4:0] w, logic [5:0] h);
		logic [11:0] a;
		int          k;
		push_entry(12'(slot), off, w, h);
		for (k = 0; k < plan_w[slot] * ((plan_h[slot] + 7) / 8); k++) begin
			a = 12'(off + k);
			if (!known_byte[a] || $urandom_range(0, 3) == 0)
				push_byte(a, 8'($urandom));
		end
	endtask

	task automatic define_random_glyph(int slot);
		if ($urandom_range(0, 9) == 0)
			define_glyph(slot, 12'($urandom), 5'($urandom_range(0, 31)),
				6'($urandom_range(0, 63)));
		else
			define_glyph(slot, 12'($urandom), 5'($urandom_range(0, 8)),
				6'($urandom_range(0, 20)));
	endtask

	function automatic bit drawable(logic [7:0] code);
		int slot;
		int k;
		if (code == bftr_pkg::CH_NEWLINE || code == bftr_pkg::CH_RETURN ||
				code < gen_first || code > gen_last)
			return 1'b1;
		slot = code - gen_first;
		if (!known_slot[slot])
			return 1'b0;
		for (k = 0; k < plan_w[slot] * ((plan_h[slot] + 7) / 8); k++)
			if (!known_byte[12'(plan_off[slot] + k)])
				return 1'b0;
		return 1'b1;
	endfunction

	task automatic random_step();
		int          pick;
		logic [7:0]  code;
		logic [15:0] x;
		pick = $urandom_range(0, 99);
		if (pick < 40) begin
			if (gen_first <= gen_last) begin
				code = 8'($urandom_range(gen_first, gen_last));
				if (!drawable(code))
					define_random_glyph(code - gen_first);
				push_char(code);
			end else begin
				push_char(8'($urandom));
			end
		end else if (pick < 52) begin
			define_random_glyph($urandom_range(0, SLOTS - 1));
		end else if (pick < 62) begin
			push_byte(12'($urandom), 8'($urandom));
		end else if (pick < 68) begin
			push_entry(12'($urandom_range(SLOTS, 4095)), 12'($urandom), 5'($urandom),
				6'($urandom));
		end else if (pick < 80) begin
			if ($urandom_range(0, 1) == 0)
				x = 16'(gen_width - $urandom_range(0, 24));
			else
				x = 16'($urandom);
			push_cursor(x, 16'($urandom));
		end else if (pick < 88) begin
			push_char(bftr_pkg::CH_NEWLINE);
		end else if (pick < 92) begin
			push_char(bftr_pkg::CH_RETURN);
		end else begin
			code = 8'($urandom);
			push_char(drawable(code) ? code : bftr_pkg::CH_RETURN);
		end
	endtask

	task automatic run_random(int n);
		int target;
		target = queued + n;
		while (queued < target)
			random_step();
	endtask

	task automatic settle();
		while (req_pending.size() != 0 || req_valid || expected_columns.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic write_reg(bftr_pkg::cfg_reg_t idx, int v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= 16'(v);
	endtask

	task automatic set_all(int f_lo, int f_hi, int gap, int scale, int wrap, int width,
			int fcol, int bcol);
		write_reg(bftr_pkg::CFG_FIRST_CHAR, f_lo);
		write_reg(bftr_pkg::CFG_LAST_CHAR, f_hi);
		write_reg(bftr_pkg::CFG_SPACE_WIDTH, gap);
		write_reg(bftr_pkg::CFG_TEXT_SCALE, scale);
		write_reg(bftr_pkg::CFG_WRAP_ENABLE, wrap);
		write_reg(bftr_pkg::CFG_DISPLAY_WIDTH, width);
		write_reg(bftr_pkg::CFG_FG_COLOR, fcol);
		write_reg(bftr_pkg::CFG_BG_COLOR, bcol);
		@(negedge clk);
		cfg_we <= 1'b0;
		gen_first = f_lo;
		gen_last = f_hi;
		gen_width = width;
		settings_applied++;
	endtask

	initial begin
		int          lo;
		logic [15:0] fcol;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		idle_on = 1'b1;

		// reset registers: font 32..126, display width 128, wrap on
		define_glyph(33, 12'd4094, 5'd3, 6'd12);
		push_byte(12'd4095, 8'hFF);
		push_char(8'd65);
		define_glyph(34, 12'd100, 5'd31, 6'd0);
		push_char(8'd66);
		define_glyph(35, 12'd200, 5'd1, 6'd63);
		push_char(8'd67);
		define_glyph(36, 12'd300, 5'd0, 6'd8);
		push_char(8'd68);
		push_entry(12'd4095, 12'd7, 5'd2, 6'd8);
		push_char(bftr_pkg::CH_NEWLINE);
		push_char(bftr_pkg::CH_RETURN);
		push_char(8'd31);
		push_char(8'd127);
		push_char(8'd255);
		push_cursor(16'h7FFF, 16'h8000);
		push_char(8'd65);
		push_cursor(16'd120, 16'd0);
		push_char(8'd67);
		push_cursor(16'h8000, 16'h7FFF);
		push_char(8'd65);
		run_random(10);

		settle();
		set_all(0, 255, 0, 0, 0, 8, 16'h0000, 16'hFFFF);
		run_random(12);

		settle();
		idle_on = 1'b0;
		set_all(255, 255, 15, 15, 1, 2047, 16'h8000, 16'h7FFF);
		run_random(10);

		settle();
		idle_on = 1'b1;
		set_all(200, 100, 3, 2, 1, 0, 16'h1234, 16'h1234);
		run_random(6);

		settle();
		lo = $urandom_range(0, 127);
		fcol = 16'($urandom);
		set_all(lo, $urandom_range(lo, 255), $urandom_range(0, 15), $urandom_range(0, 15),
			$urandom_range(0, 1), $urandom_range(0, 2047), fcol,
			$urandom_range(0, 1) ? fcol : 16'($urandom));
		run_random(12);

		settle();
		if (expected_columns.size() != 0)
			log_error($sformatf("%0d columns never arrived", expected_columns.size()));
		$display("%0d requests accepted, %0d glyph columns compared over %0d register settings",
			accepted_reqs, columns_checked, settings_applied + 1);
		$display("%0d mismatches", error_count);
		if (error_count == 0)
			$display("tb_bitmap_font_text_renderer: clean");
		else
			$display("tb_bitmap_font_text_renderer: errors");
		$finish;
	end

endmodule
